// ===== hw/rtl/beacon_direction_mode_filter_unit_macros.svh =====
// assertion macros shared by the beacon filter rtl
`ifndef BEACON_DIRECTION_MODE_FILTER_UNIT_MACROS_SVH
`define BEACON_DIRECTION_MODE_FILTER_UNIT_MACROS_SVH

`ifndef SYNTHESIS
`define BDMF_ASSERT(lbl, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);
`define BDMF_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define BDMF_ASSERT(lbl, expr, msg)
`define BDMF_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

// ===== hw/rtl/bdmf_pkg.sv =====
// types and constants of the beacon direction mode filter
package bdmf_pkg;

    localparam int LEVEL_W        = 10;
    localparam int WINDOW_DEFAULT = 10;
    localparam int QUEUE_DEPTH    = 2;
    localparam int CFG_ADDR_W     = 3;
    localparam int CFG_DATA_W     = 32;

    localparam logic [LEVEL_W-1:0] THRESHOLD_RESET = 10'd500;

    // register index taken from paddr[2]
    localparam logic [0:0] REG_THRESHOLD = 1'b0;

    typedef logic [LEVEL_W-1:0] level_t;

    typedef enum logic [1:0] {
        DIR_NORTH = 2'd0,
        DIR_EAST  = 2'd1,
        DIR_SOUTH = 2'd2,
        DIR_WEST  = 2'd3
    } dir_t;

    // word passed from the classifier to the tally stage
    typedef struct packed {
        dir_t instant;
        logic found;
    } mid_word_t;

    // result word
    typedef struct packed {
        dir_t instant;
        dir_t smoothed;
        logic found;
    } out_word_t;

endpackage

// ===== hw/rtl/bdmf_fifo.sv =====
// small register fifo used between the front, the back and the result side
`include "beacon_direction_mode_filter_unit_macros.svh"

module bdmf_fifo #(
    parameter int WIDTH = 3,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] rdata,
    output logic             empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

    `BDMF_ASSERT(count_in_range, count_reg <= CNT_W'(DEPTH), "fifo count above depth")
    `BDMF_ASSERT_NEXT(count_grows, do_push && !do_pop, count_reg == $past(count_reg) + CNT_W'(1), "fifo count did not grow on push")

endmodule

// ===== hw/rtl/bdmf_front.sv =====
// front end: picks the strongest direction and the beacon flag of one sample
module bdmf_front (
    input  bdmf_pkg::level_t    west_level,
    input  bdmf_pkg::level_t    south_level,
    input  bdmf_pkg::level_t    east_level,
    input  bdmf_pkg::level_t    north_level,
    input  bdmf_pkg::level_t    threshold,
    output bdmf_pkg::mid_word_t word
);

    bdmf_pkg::level_t best;
    bdmf_pkg::dir_t   dir;

    // scan west, south, east, north; strict less keeps the earliest minimum
    always_comb
    begin
        best = west_level;
        dir  = bdmf_pkg::DIR_WEST;
        if (south_level < best)
        begin
            best = south_level;
            dir  = bdmf_pkg::DIR_SOUTH;
        end
        if (east_level < best)
        begin
            best = east_level;
            dir  = bdmf_pkg::DIR_EAST;
        end
        if (north_level < best)
        begin
            best = north_level;
            dir  = bdmf_pkg::DIR_NORTH;
        end
    end

    assign word.instant = dir;
    assign word.found   = (west_level >= threshold) || (south_level >= threshold) ||
                          (east_level >= threshold) || (north_level >= threshold);

endmodule

// ===== hw/rtl/bdmf_back.sv =====
// back end: direction history, per-direction tallies and the mode pick
`include "beacon_direction_mode_filter_unit_macros.svh"

module bdmf_back #(
    parameter int WINDOW = bdmf_pkg::WINDOW_DEFAULT
) (
    input  logic                clk,
    input  logic                rst_n,
    input  bdmf_pkg::mid_word_t in_word,
    input  logic                in_empty,
    output logic                in_pop,
    input  logic                out_full,
    output logic                out_push,
    output bdmf_pkg::out_word_t out_word
);

    localparam int CNT_W = $clog2(WINDOW + 1);
    localparam int SUM_W = CNT_W + 2;

    bdmf_pkg::dir_t   ring_reg [WINDOW];
    logic [CNT_W-1:0] tally_reg [4];
    logic [CNT_W-1:0] tally_next [4];
    bdmf_pkg::dir_t   oldest;
    bdmf_pkg::dir_t   mode;
    logic             take;

    assign take     = !in_empty && !out_full;
    assign in_pop   = take;
    assign out_push = take;
    // the history is a shift line, its last tap is the entry that drops out
    assign oldest   = ring_reg[WINDOW-1];

    always_comb
    begin
        for (int d = 0; d < 4; d++)
        begin
            tally_next[d] = tally_reg[d]
                - CNT_W'((oldest == bdmf_pkg::dir_t'(2'(d))) && (tally_reg[d] != '0))
                + CNT_W'(in_word.instant == bdmf_pkg::dir_t'(2'(d)));
        end
    end

    // greatest tally, ties to the lower code
    always_comb
    begin
        mode = bdmf_pkg::DIR_NORTH;
        for (int i = 1; i < 4; i++)
        begin
            if (tally_next[i] > tally_next[mode])
            begin
                mode = bdmf_pkg::dir_t'(2'(i));
            end
        end
    end

    assign out_word.instant  = in_word.instant;
    assign out_word.smoothed = mode;
    assign out_word.found    = in_word.found;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < WINDOW; i++)
            begin
                ring_reg[i] <= bdmf_pkg::DIR_NORTH;
            end
            tally_reg[0] <= CNT_W'(WINDOW);
            tally_reg[1] <= '0;
            tally_reg[2] <= '0;
            tally_reg[3] <= '0;
        end
        else if (take)
        begin
            ring_reg[0] <= in_word.instant;
            for (int i = 1; i < WINDOW; i++)
            begin
                ring_reg[i] <= ring_reg[i-1];
            end
            for (int d = 0; d < 4; d++)
            begin
                tally_reg[d] <= tally_next[d];
            end
        end
    end

    `BDMF_ASSERT(tally_sum_window, SUM_W'(tally_reg[0]) + SUM_W'(tally_reg[1]) + SUM_W'(tally_reg[2]) + SUM_W'(tally_reg[3]) == SUM_W'(WINDOW), "tallies do not sum to the window")
    `BDMF_ASSERT_NEXT(ring_takes_word, take, ring_reg[0] == $past(in_word.instant), "history did not take the word")

endmodule

// ===== hw/rtl/beacon_direction_mode_filter_unit.sv =====
// top level of the beacon direction mode filter
//
// input channel: push a word of four 10-bit readings (west, south, east,
// north) while full is low; lower readings mean a stronger beacon.
// result channel: while empty is low the oldest result sits on
// instant_direction, smoothed_direction and beacon_found; pop takes it.
// direction codes: 0 north, 1 east, 2 south, 3 west.
// config: apb-style port, beacon_threshold at byte address 0, pready tied
// high, writes take effect when psel, penable and pwrite are high.
// path: an accepted word is held in the middle queue, moved by the back
// end into the result queue, and is then poppable.
// throughput: one word per cycle while the receiver keeps popping, set by
// the tally update of the back end; two-entry queues sit between front
// and back and on the result side, so either side may stall alone.
// a stalled receiver fills the result queue, then the middle queue, then
// full rises; nothing is dropped.
// reset: queues empty, history all north, north tally at the window size,
// threshold 500; no clearing pass is needed.
module beacon_direction_mode_filter_unit #(
    parameter int WINDOW      = bdmf_pkg::WINDOW_DEFAULT,
    parameter int QUEUE_DEPTH = bdmf_pkg::QUEUE_DEPTH
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            push,
    output logic                            full,
    input  logic [bdmf_pkg::LEVEL_W-1:0]    west_level,
    input  logic [bdmf_pkg::LEVEL_W-1:0]    south_level,
    input  logic [bdmf_pkg::LEVEL_W-1:0]    east_level,
    input  logic [bdmf_pkg::LEVEL_W-1:0]    north_level,
    input  logic                            pop,
    output logic                            empty,
    output logic [1:0]                      instant_direction,
    output logic [1:0]                      smoothed_direction,
    output logic                            beacon_found,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [bdmf_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [bdmf_pkg::CFG_DATA_W-1:0] pwdata,
    output logic [bdmf_pkg::CFG_DATA_W-1:0] prdata,
    output logic                            pready
);

    bdmf_pkg::level_t    threshold_reg;
    bdmf_pkg::mid_word_t front_word;
    bdmf_pkg::mid_word_t mid_word;
    bdmf_pkg::out_word_t back_word;
    bdmf_pkg::out_word_t res_word;
    logic                mid_empty;
    logic                mid_pop;
    logic                res_full;
    logic                res_push;
    logic                cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg <= bdmf_pkg::THRESHOLD_RESET;
        end
        else if (cfg_write && (paddr[2] == bdmf_pkg::REG_THRESHOLD))
        begin
            threshold_reg <= pwdata[bdmf_pkg::LEVEL_W-1:0];
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            bdmf_pkg::REG_THRESHOLD:
            begin
                prdata = bdmf_pkg::CFG_DATA_W'(threshold_reg);
            end
            default:
            begin
                prdata = '0;
            end
        endcase
    end

    bdmf_front u_front (
        .west_level  (west_level),
        .south_level (south_level),
        .east_level  (east_level),
        .north_level (north_level),
        .threshold   (threshold_reg),
        .word        (front_word)
    );

    bdmf_fifo #(
        .WIDTH ($bits(bdmf_pkg::mid_word_t)),
        .DEPTH (QUEUE_DEPTH)
    ) u_mid_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .wdata (front_word),
        .full  (full),
        .pop   (mid_pop),
        .rdata (mid_word),
        .empty (mid_empty)
    );

    bdmf_back #(
        .WINDOW (WINDOW)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_word  (mid_word),
        .in_empty (mid_empty),
        .in_pop   (mid_pop),
        .out_full (res_full),
        .out_push (res_push),
        .out_word (back_word)
    );

    bdmf_fifo #(
        .WIDTH ($bits(bdmf_pkg::out_word_t)),
        .DEPTH (QUEUE_DEPTH)
    ) u_res_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (res_push),
        .wdata (back_word),
        .full  (res_full),
        .pop   (pop),
        .rdata (res_word),
        .empty (empty)
    );

    assign instant_direction  = res_word.instant;
    assign smoothed_direction = res_word.smoothed;
    assign beacon_found       = res_word.found;

endmodule
